### hw/rtl/amr_pkg.sv
package amr_pkg;

    // stream field widths
    localparam int SAMPLE_BITS = 16;
    localparam int SUM_BITS    = 28;
    localparam int MEAN_BITS   = 24;
    localparam int INDEX_BITS  = 26;
    localparam int FRAC_BITS   = 8;

    // running-sum store and position counters
    localparam int MAX_INNER   = 1024;
    localparam int INNER_BITS  = $clog2(MAX_INNER);
    localparam int MAX_AXIS    = 4096;
    localparam int AXIS_BITS   = $clog2(MAX_AXIS);
    localparam int OUTER_LIMIT = 65536;
    localparam int OUTER_BITS  = $clog2(OUTER_LIMIT);

    // configuration registers
    localparam int OUTER_CFG_BITS = 17;
    localparam int AXIS_CFG_BITS  = 13;
    localparam int INNER_CFG_BITS = 11;
    localparam int CFG_DATA_BITS  = 17;
    localparam int CFG_INDEX_BITS = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_OUTER_COUNT = 2'd0,
        REG_AXIS_LENGTH = 2'd1,
        REG_INNER_COUNT = 2'd2
    } cfg_reg_t;

    // divider
    localparam int DIV_BITS     = SUM_BITS + FRAC_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_BITS + 1);
    localparam int REM_BITS     = AXIS_CFG_BITS;

    localparam logic [DIV_BITS-1:0] MEAN_POS_LIMIT = DIV_BITS'(2 ** (MEAN_BITS - 1) - 1);
    localparam logic [DIV_BITS-1:0] MEAN_NEG_LIMIT = DIV_BITS'(2 ** (MEAN_BITS - 1));
    localparam logic [MEAN_BITS-1:0] MEAN_MAX = MEAN_BITS'(2 ** (MEAN_BITS - 1) - 1);
    localparam logic [MEAN_BITS-1:0] MEAN_MIN = MEAN_BITS'(2 ** (MEAN_BITS - 1));

    typedef struct packed {
        logic                       start;
        logic signed [SUM_BITS-1:0] sum;
    } div_req_t;

    typedef struct packed {
        logic                        done;
        logic signed [MEAN_BITS-1:0] mean;
    } div_rsp_t;

    typedef struct packed {
        logic                       en;
        logic [INNER_BITS-1:0]      addr;
        logic signed [SUM_BITS-1:0] data;
    } mem_wr_t;

    typedef struct packed {
        logic                  en;
        logic [INNER_BITS-1:0] addr;
    } mem_rd_t;

endpackage

### hw/rtl/amr_stream_if.sv
// input beat: one tensor element
interface amr_sample_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [amr_pkg::SAMPLE_BITS-1:0]   sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

// output beat: one mean with its flat index
interface amr_mean_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [amr_pkg::MEAN_BITS-1:0]     mean_value;
    logic [amr_pkg::INDEX_BITS-1:0]           out_index;
    logic                                     last;

    modport source (output valid, output mean_value, output out_index, output last,
                    input ready);
    modport sink (input valid, input mean_value, input out_index, input last,
                  output ready);
endinterface

### hw/rtl/amr_sum_mem.sv
module amr_sum_mem (
    input  logic                                   clk,
    input  amr_pkg::mem_wr_t                       wr,
    input  amr_pkg::mem_rd_t                       rd,
    output logic signed [amr_pkg::SUM_BITS-1:0]    rd_data
);

    logic signed [amr_pkg::SUM_BITS-1:0] sums [amr_pkg::MAX_INNER];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            sums[wr.addr] <= wr.data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data <= sums[rd.addr];
        end
    end

endmodule

### hw/rtl/amr_divider.sv
module amr_divider (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  amr_pkg::div_req_t                     req,
    input  logic [amr_pkg::AXIS_CFG_BITS-1:0]     divisor,
    output amr_pkg::div_rsp_t                     rsp
);

    logic                                 busy_reg;
    logic                                 done_reg;
    logic [amr_pkg::DIV_CNT_BITS-1:0]     cnt_reg;
    logic                                 neg_reg;
    logic [amr_pkg::DIV_BITS-1:0]         quo_reg;
    logic [amr_pkg::REM_BITS-1:0]         rem_reg;

    logic [amr_pkg::SUM_BITS-1:0]         magnitude;
    logic [amr_pkg::REM_BITS:0]           trial;
    logic                                 fits;
    logic [amr_pkg::REM_BITS:0]           trial_diff;
    logic [amr_pkg::MEAN_BITS-1:0]        mean_sat;

    // magnitude of the sum, then shifted up by the fraction bits
    assign magnitude = req.sum[amr_pkg::SUM_BITS-1] ? amr_pkg::SUM_BITS'(-req.sum)
                                                    : amr_pkg::SUM_BITS'(req.sum);

    // one restoring step per cycle
    assign trial      = {rem_reg, quo_reg[amr_pkg::DIV_BITS-1]};
    assign fits       = trial >= {1'b0, divisor};
    assign trial_diff = trial - {1'b0, divisor};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= amr_pkg::DIV_CNT_BITS'(amr_pkg::DIV_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == amr_pkg::DIV_CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: quotient bits shift in as dividend bits shift out
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            neg_reg <= req.sum[amr_pkg::SUM_BITS-1];
            quo_reg <= {magnitude, amr_pkg::FRAC_BITS'(0)};
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[amr_pkg::DIV_BITS-2:0], fits};
            rem_reg <= fits ? trial_diff[amr_pkg::REM_BITS-1:0]
                            : trial[amr_pkg::REM_BITS-1:0];
        end
    end

    // sign restore and saturation
    always_comb
    begin
        if (neg_reg)
        begin
            if (quo_reg > amr_pkg::MEAN_NEG_LIMIT)
                mean_sat = amr_pkg::MEAN_MIN;
            else
                mean_sat = ~quo_reg[amr_pkg::MEAN_BITS-1:0] + 1'b1;
        end
        else
        begin
            if (quo_reg > amr_pkg::MEAN_POS_LIMIT)
                mean_sat = amr_pkg::MEAN_MAX;
            else
                mean_sat = quo_reg[amr_pkg::MEAN_BITS-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.mean = mean_sat;

endmodule

### hw/rtl/axis_mean_reduce.sv
// Mean of a tensor along one axis. Elements enter one beat at a time in row-major
// order, seen as outer_count x axis_length x inner_count with the inner position
// fastest. One 28-bit running sum per inner position lives in a 1024-entry
// synchronous RAM; the first axis step overwrites its entry, so the RAM needs no
// clearing after reset. On the last axis step the sum is divided by axis_length
// and a mean beat leaves with 8 fraction bits (truncated toward zero, saturated to
// 24 bits), its flat index outer*inner_count+inner and a last flag on the final
// mean. An element that does not close its axis is read from the RAM, then added and
// written back; one that closes its axis also waits for the radix-2 divider, which
// takes 36 steps. The result sits in an output register, so a
// new element is taken while the previous mean waits on a stalled sink. Writing
// any configuration register restarts the tensor; 0 is taken as 1 and oversized
// values are clamped to 65536, 4096 and 1024.
module axis_mean_reduce (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [amr_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [amr_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    amr_sample_if.sink                             samples,
    amr_mean_if.source                             means
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ACC  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t                                  state_reg;
    state_t                                  state_next;

    logic [amr_pkg::OUTER_CFG_BITS-1:0]      outer_count_reg;
    logic [amr_pkg::AXIS_CFG_BITS-1:0]       axis_length_reg;
    logic [amr_pkg::INNER_CFG_BITS-1:0]      inner_count_reg;

    logic [amr_pkg::INNER_BITS-1:0]          inner_pos_reg;
    logic [amr_pkg::AXIS_BITS-1:0]           axis_pos_reg;
    logic [amr_pkg::OUTER_BITS-1:0]          outer_pos_reg;

    logic signed [amr_pkg::SAMPLE_BITS-1:0]  sample_reg;
    logic [amr_pkg::INNER_BITS-1:0]          slot_reg;
    logic                                    first_reg;
    logic                                    close_reg;
    logic [amr_pkg::INDEX_BITS-1:0]          index_reg;
    logic                                    fin_reg;

    logic                                    out_valid_reg;
    logic signed [amr_pkg::MEAN_BITS-1:0]    out_mean_reg;
    logic [amr_pkg::INDEX_BITS-1:0]          out_index_reg;
    logic                                    out_last_reg;

    logic                                    accept;
    logic                                    inner_wrap;
    logic                                    axis_wrap;
    logic                                    outer_wrap;
    logic [amr_pkg::INDEX_BITS:0]            index_prod;
    logic [amr_pkg::OUTER_CFG_BITS-1:0]      outer_value;
    logic [amr_pkg::AXIS_CFG_BITS-1:0]       axis_value;
    logic [amr_pkg::INNER_CFG_BITS-1:0]      inner_value;
    logic signed [amr_pkg::SUM_BITS-1:0]     sample_ext;
    logic signed [amr_pkg::SUM_BITS-1:0]     rd_data;
    logic signed [amr_pkg::SUM_BITS-1:0]     sum;
    logic                                    out_free;

    amr_pkg::mem_wr_t                        mem_wr;
    amr_pkg::mem_rd_t                        mem_rd;
    amr_pkg::div_req_t                       div_req;
    amr_pkg::div_rsp_t                       div_rsp;

    assign accept = samples.valid && samples.ready;
    assign samples.ready = (state_reg == ST_IDLE);

    // position wrap detection
    assign inner_wrap = ({1'b0, inner_pos_reg} + 1'b1) >= inner_count_reg;
    assign axis_wrap  = ({1'b0, axis_pos_reg} + 1'b1) >= axis_length_reg;
    assign outer_wrap = ({1'b0, outer_pos_reg} + 1'b1) >= outer_count_reg;

    // flat output index
    assign index_prod = (amr_pkg::INDEX_BITS + 1)'(outer_pos_reg)
                      * (amr_pkg::INDEX_BITS + 1)'(inner_count_reg)
                      + (amr_pkg::INDEX_BITS + 1)'(inner_pos_reg);

    // register write clamping
    always_comb
    begin
        outer_value = cfg_data[amr_pkg::OUTER_CFG_BITS-1:0];
        if (outer_value == '0)
            outer_value = amr_pkg::OUTER_CFG_BITS'(1);
        else if (outer_value > amr_pkg::OUTER_CFG_BITS'(amr_pkg::OUTER_LIMIT))
            outer_value = amr_pkg::OUTER_CFG_BITS'(amr_pkg::OUTER_LIMIT);

        axis_value = cfg_data[amr_pkg::AXIS_CFG_BITS-1:0];
        if (axis_value == '0)
            axis_value = amr_pkg::AXIS_CFG_BITS'(1);
        else if (axis_value > amr_pkg::AXIS_CFG_BITS'(amr_pkg::MAX_AXIS))
            axis_value = amr_pkg::AXIS_CFG_BITS'(amr_pkg::MAX_AXIS);

        inner_value = cfg_data[amr_pkg::INNER_CFG_BITS-1:0];
        if (inner_value == '0)
            inner_value = amr_pkg::INNER_CFG_BITS'(1);
        else if (inner_value > amr_pkg::INNER_CFG_BITS'(amr_pkg::MAX_INNER))
            inner_value = amr_pkg::INNER_CFG_BITS'(amr_pkg::MAX_INNER);
    end

    // configuration registers and position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outer_count_reg <= amr_pkg::OUTER_CFG_BITS'(1);
            axis_length_reg <= amr_pkg::AXIS_CFG_BITS'(1);
            inner_count_reg <= amr_pkg::INNER_CFG_BITS'(1);
            inner_pos_reg   <= '0;
            axis_pos_reg    <= '0;
            outer_pos_reg   <= '0;
        end
        else if (cfg_we && (cfg_index == amr_pkg::REG_OUTER_COUNT ||
                            cfg_index == amr_pkg::REG_AXIS_LENGTH ||
                            cfg_index == amr_pkg::REG_INNER_COUNT))
        begin
            case (cfg_index)
                amr_pkg::REG_OUTER_COUNT: outer_count_reg <= outer_value;
                amr_pkg::REG_AXIS_LENGTH: axis_length_reg <= axis_value;
                amr_pkg::REG_INNER_COUNT: inner_count_reg <= inner_value;
                default: ;
            endcase
            inner_pos_reg <= '0;
            axis_pos_reg  <= '0;
            outer_pos_reg <= '0;
        end
        else if (accept)
        begin
            if (inner_wrap)
            begin
                inner_pos_reg <= '0;
                if (axis_wrap)
                begin
                    axis_pos_reg  <= '0;
                    outer_pos_reg <= outer_wrap ? '0 : outer_pos_reg + 1'b1;
                end
                else
                begin
                    axis_pos_reg <= axis_pos_reg + 1'b1;
                end
            end
            else
            begin
                inner_pos_reg <= inner_pos_reg + 1'b1;
            end
        end
    end

    // capture the beat and what the counters say about it
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= samples.sample;
            slot_reg   <= inner_pos_reg;
            first_reg  <= (axis_pos_reg == '0);
            close_reg  <= axis_wrap;
            index_reg  <= index_prod[amr_pkg::INDEX_BITS-1:0];
            fin_reg    <= outer_wrap && inner_wrap;
        end
    end

    // running-sum RAM: read on accept, write back in the following cycle
    assign mem_rd.en   = accept;
    assign mem_rd.addr = inner_pos_reg;

    assign sample_ext = amr_pkg::SUM_BITS'(sample_reg);
    assign sum        = first_reg ? sample_ext : rd_data + sample_ext;

    assign mem_wr.en   = (state_reg == ST_ACC);
    assign mem_wr.addr = slot_reg;
    assign mem_wr.data = sum;

    amr_sum_mem u_sum_mem (
        .clk     (clk),
        .wr      (mem_wr),
        .rd      (mem_rd),
        .rd_data (rd_data)
    );

    // mean division
    assign div_req.start = (state_reg == ST_ACC) && close_reg;
    assign div_req.sum   = sum;

    amr_divider u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (div_req),
        .divisor (axis_length_reg),
        .rsp     (div_rsp)
    );

    // sequencer
    assign out_free = !out_valid_reg || means.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_ACC;
            ST_ACC:  state_next = close_reg ? ST_DIV : ST_IDLE;
            ST_DIV:  if (div_rsp.done) state_next = ST_FIN;
            ST_FIN:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_FIN && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (means.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FIN && out_free)
        begin
            out_mean_reg  <= div_rsp.mean;
            out_index_reg <= index_reg;
            out_last_reg  <= fin_reg;
        end
    end

    assign means.valid      = out_valid_reg;
    assign means.mean_value = out_mean_reg;
    assign means.out_index  = out_index_reg;
    assign means.last       = out_last_reg;

    // checks
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, inner_pos_reg} < inner_count_reg) && ({1'b0, axis_pos_reg} < axis_length_reg))
        else $error("position counter beyond configured size");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    a_start_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC) && close_reg |=> (state_reg == ST_DIV))
        else $error("closing beat did not start a division");

    a_ram_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr.en |-> $past(accept))
        else $error("sum write-back without a preceding read");

endmodule

### tb/sv/tb_top.sv
module tb_top;

    localparam int IDLE_CYCLES  = 64;
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 1250;
    localparam int REPORT_LIMIT = 10;
    localparam int PHASE_CAP    = 400;

    // register indexes as used in the directed table
    localparam logic [amr_pkg::CFG_INDEX_BITS-1:0] REG_OUTER = amr_pkg::REG_OUTER_COUNT;
    localparam logic [amr_pkg::CFG_INDEX_BITS-1:0] REG_AXIS  = amr_pkg::REG_AXIS_LENGTH;
    localparam logic [amr_pkg::CFG_INDEX_BITS-1:0] REG_INNER = amr_pkg::REG_INNER_COUNT;

    // index with no register behind it
    localparam logic [amr_pkg::CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;

    localparam longint MEAN_HI = (longint'(1) <<< (amr_pkg::MEAN_BITS - 1)) - 1;
    localparam longint MEAN_LO = -(longint'(1) <<< (amr_pkg::MEAN_BITS - 1));

    typedef struct packed {
        logic signed [amr_pkg::MEAN_BITS-1:0] mean_value;
        logic [amr_pkg::INDEX_BITS-1:0]       out_index;
        logic                                 last;
    } mean_beat_t;

    typedef struct packed {
        bit         pinned;
        mean_beat_t beat;
    } pinned_beat_t;

    typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef enum int {FILL_RANDOM, FILL_CORNER, FILL_MIN} fill_t;

    typedef struct packed {
        row_kind_t                              kind;
        logic [amr_pkg::CFG_INDEX_BITS-1:0]     reg_index;
        logic [amr_pkg::CFG_DATA_BITS-1:0]      reg_value;
        logic signed [amr_pkg::SAMPLE_BITS-1:0] sample;
        bit                                     pinned;
        mean_beat_t                             beat;
    } plan_row_t;

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_we;
    logic [amr_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [amr_pkg::CFG_DATA_BITS-1:0]  cfg_data;

    amr_sample_if sample_bus ();
    amr_mean_if   mean_bus ();

    axis_mean_reduce DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (sample_bus),
        .means     (mean_bus)
    );

    // mirror of the running sums, counters and size registers
    longint       axis_sums [amr_pkg::MAX_INNER];
    int unsigned  inner_at;
    int unsigned  axis_at;
    int unsigned  outer_at;
    int unsigned  outer_cnt;
    int unsigned  axis_len;
    int unsigned  inner_cnt;

    mean_beat_t   pending_means [$];
    pinned_beat_t pinned_q [$];
    int           failures;
    int           idle_run;
    int           burst_left;
    bit           dirty;

    // directed walk: reset sizes, restart on write, zero sizes, spare index
    plan_row_t plan [28] = '{
        '{ROW_SAMPLE, REG_OUTER, 17'd0, 16'sh0000, 1'b1, '{24'h000000, 26'd0, 1'b1}},
        '{ROW_SAMPLE, REG_OUTER, 17'd0, 16'sh0001, 1'b1, '{24'h000100, 26'd0, 1'b1}},
        '{ROW_SAMPLE, REG_OUTER, 17'd0, 16'shFFFF, 1'b1, '{24'hFFFF00, 26'd0, 1'b1}},
        '{ROW_SAMPLE, REG_OUTER, 17'd0, 16'sh7FFF, 1'b1, '{24'h7FFF00, 26'd0, 1'b1}},
        '{ROW_SAMPLE, REG_OUTER, 17'd0, 16'sh8000, 1'b1, '{24'h800000, 26'd0, 1'b1}},
        '{ROW_SAMPLE, REG_OUTER, 17'd0, 16'sh5555, 1'b1, '{24'h555500, 26'd0, 1'b1}},
        '{ROW_SAMPLE, REG_OUTER, 17'd0, 16'shAAAA, 1'b1, '{24'hAAAA00, 26'd0, 1'b1}},
        '{ROW_WRITE,  REG_AXIS,  17'd3, 16'sh0000, 1'b0, '0},
        '{ROW_WRITE,  REG_INNER, 17'd2, 16'sh0000, 1'b0, '0},
        '{ROW_WRITE,  REG_OUTER, 17'd2, 16'sh0000, 1'b0, '0},
        '{ROW_SAMPLE, REG_OUTER, 17'd0, 16'sd7,    1'b0, '0},
        '{ROW_SAMPLE, REG_OUTER, 17'd0, -16'sd7,   1'b0, '0},
        '{ROW_SAMPLE, REG_OUTER, 17'd0, 16'sd100,  1'b0, '0},
        '{ROW_SAMPLE, REG_OUTER, 17'd0, -16'sd1,   1'b0, '0},
        '{ROW_SAMPLE, REG_OUTER, 17'd0, 16'sd5,    1'b0, '0},
        '{ROW_SAMPLE, REG_OUTER, 17'd0, -16'sd3,   1'b0, '0},
        '{ROW_WRITE,  REG_SPARE, 17'd5, 16'sh0000, 1'b0, '0},
        '{ROW_SAMPLE, REG_OUTER, 17'd0, 16'sd3,    1'b0, '0},
        '{ROW_WRITE,  REG_OUTER, 17'd0, 16'sh0000, 1'b0, '0},
        '{ROW_SAMPLE, REG_OUTER, 17'd0, 16'sh8000, 1'b0, '0},
        '{ROW_SAMPLE, REG_OUTER, 17'd0, 16'sh7FFF, 1'b0, '0},
        '{ROW_SAMPLE, REG_OUTER, 17'd0, 16'sh8000, 1'b0, '0},
        '{ROW_SAMPLE, REG_OUTER, 17'd0, 16'sh7FFF, 1'b0, '0},
        '{ROW_SAMPLE, REG_OUTER, 17'd0, 16'sh8000, 1'b1, '{24'h800000, 26'd0, 1'b0}},
        '{ROW_SAMPLE, REG_OUTER, 17'd0, 16'sh7FFF, 1'b1, '{24'h7FFF00, 26'd1, 1'b1}},
        '{ROW_WRITE,  REG_AXIS,  17'd0, 16'sh0000, 1'b0, '0},
        '{ROW_SAMPLE, REG_OUTER, 17'd0, 16'sh8000, 1'b1, '{24'h800000, 26'd0, 1'b0}},
        '{ROW_SAMPLE, REG_OUTER, 17'd0, 16'sh7FFF, 1'b1, '{24'h7FFF00, 26'd1, 1'b1}}
    };

    // zero means one, oversized values clamp to the limit
    function automatic int unsigned clamp_size(longint unsigned v, int unsigned limit);
        if (v == 0)
            return 1;
        if (v > limit)
            return limit;
        return int'(v);
    endfunction

    function void apply_register(logic [amr_pkg::CFG_INDEX_BITS-1:0] idx,
                                 logic [amr_pkg::CFG_DATA_BITS-1:0] value);
        case (idx)
            amr_pkg::REG_OUTER_COUNT:
                outer_cnt = clamp_size(value[amr_pkg::OUTER_CFG_BITS-1:0],
                                       amr_pkg::OUTER_LIMIT);
            amr_pkg::REG_AXIS_LENGTH:
                axis_len  = clamp_size(value[amr_pkg::AXIS_CFG_BITS-1:0],
                                       amr_pkg::MAX_AXIS);
            amr_pkg::REG_INNER_COUNT:
                inner_cnt = clamp_size(value[amr_pkg::INNER_CFG_BITS-1:0],
                                       amr_pkg::MAX_INNER);
            default:
                return;
        endcase
        inner_at = 0;
        axis_at  = 0;
        outer_at = 0;
    endfunction

    // fold one element into its running sum, emit the mean on the last axis step
    function void fold_element(input logic signed [amr_pkg::SAMPLE_BITS-1:0] x,
                               output bit emits, output mean_beat_t beat);
        longint            sum;
        longint            mean;
        longint unsigned   flat;
        int unsigned       slot;
        slot = inner_at % amr_pkg::MAX_INNER;
        sum = (axis_at == 0) ? longint'(x) : axis_sums[slot] + longint'(x);
        axis_sums[slot] = sum;
        emits = 1'b0;
        beat = '0;
        if (axis_at + 1 >= axis_len)
        begin
            mean = (sum * (longint'(1) <<< amr_pkg::FRAC_BITS)) / longint'(axis_len);
            if (mean > MEAN_HI)
                mean = MEAN_HI;
            if (mean < MEAN_LO)
                mean = MEAN_LO;
            flat = longint'(outer_at) * longint'(inner_cnt) + longint'(inner_at);
            beat.mean_value = mean[amr_pkg::MEAN_BITS-1:0];
            beat.out_index  = flat[amr_pkg::INDEX_BITS-1:0];
            beat.last       = (outer_at + 1 >= outer_cnt) && (inner_at + 1 >= inner_cnt);
            emits = 1'b1;
        end
        inner_at++;
        if (inner_at >= inner_cnt)
        begin
            inner_at = 0;
            axis_at++;
            if (axis_at >= axis_len)
            begin
                axis_at = 0;
                outer_at++;
                if (outer_at >= outer_cnt)
                    outer_at = 0;
            end
        end
    endfunction

    function void note_failure(string what);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("[%0t] %s", $realtime, what);
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // track writes and accepted beats, check means, watch for a hang
    always @(posedge clk)
    begin
        bit           emits;
        bit           moved;
        mean_beat_t   beat;
        mean_beat_t   want;
        pinned_beat_t pin;
        moved = 1'b0;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                apply_register(cfg_index, cfg_data);
                moved = 1'b1;
            end
            if (sample_bus.valid && sample_bus.ready)
            begin
                pin = '0;
                if (pinned_q.size() != 0)
                    pin = pinned_q.pop_front();
                fold_element(sample_bus.sample, emits, beat);
                if (emits)
                    pending_means = {pending_means, (pin.pinned ? pin.beat : beat)};
                moved = 1'b1;
            end
            if (mean_bus.valid && mean_bus.ready)
            begin
                if (pending_means.size() == 0)
                begin
                    note_failure($sformatf("unexpected mean beat: mean %0d index %0d last %0b",
                                           mean_bus.mean_value, mean_bus.out_index,
                                           mean_bus.last));
                end
                else
                begin
                    want = pending_means.pop_front();
                    if (mean_bus.mean_value !== want.mean_value ||
                        mean_bus.out_index !== want.out_index ||
                        mean_bus.last !== want.last)
                    begin
                        note_failure($sformatf({"mean beat mismatch: mean exp %0d got %0d,",
                                                " index exp %0d got %0d, last exp %0b got %0b"},
                                               want.mean_value, mean_bus.mean_value,
                                               want.out_index, mean_bus.out_index,
                                               want.last, mean_bus.last));
                    end
                end
                moved = 1'b1;
            end
        end
        idle_run = moved ? 0 : idle_run + 1;
        if (idle_run >= STALL_LIMIT)
        begin
            $display("axis_mean_reduce verification failed");
            $finish;
        end
    end

    // mean sink: stretches of steady, random, periodic and mostly stalled ready
    initial
    begin
        int stretch;
        int style;
        mean_bus.ready = 1'b0;
        forever
        begin
            stretch = $urandom_range(16, 200);
            style = $urandom_range(0, 3);
            for (int k = 0; k < stretch; k++)
            begin
                @(negedge clk);
                case (style)
                    0:       mean_bus.ready <= 1'b1;
                    1:       mean_bus.ready <= 1'($urandom_range(0, 1));
                    2:       mean_bus.ready <= (k % 12) < 4;
                    default: mean_bus.ready <= ($urandom_range(0, 9) == 0);
                endcase
            end
        end
    end

    // one sample beat, bursts of random length with random gaps
    task automatic send_sample(input logic signed [amr_pkg::SAMPLE_BITS-1:0] x,
                               input bit pinned, input mean_beat_t beat);
        int           gap;
        pinned_beat_t entry;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 7) == 0) ? 400 : $urandom_range(1, 40);
            if (gap != 0)
            begin
                @(negedge clk);
                sample_bus.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        entry.pinned = pinned;
        entry.beat   = beat;
        pinned_q = {pinned_q, entry};
        dirty = 1'b1;
        @(negedge clk);
        sample_bus.valid  <= 1'b1;
        sample_bus.sample <= x;
        do
            @(posedge clk);
        while (!sample_bus.ready);
    endtask

    // register write once every mean is out and the datapath has settled
    task automatic write_reg(input logic [amr_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [amr_pkg::CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        sample_bus.valid <= 1'b0;
        while (pending_means.size() != 0)
            @(negedge clk);
        if (dirty)
            repeat (IDLE_CYCLES) @(negedge clk);
        dirty = 1'b0;
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic stream(input int n, input fill_t fill);
        logic signed [amr_pkg::SAMPLE_BITS-1:0] x;
        for (int i = 0; i < n; i++)
        begin
            case (fill)
                FILL_MIN:    x = 16'sh8000;
                FILL_CORNER:
                begin
                    case ($urandom_range(0, 5))
                        0:       x = 16'sh8000;
                        1:       x = 16'sh7FFF;
                        2:       x = 16'sh0000;
                        3:       x = 16'shFFFF;
                        4:       x = 16'sh0001;
                        default: x = 16'($urandom);
                    endcase
                end
                default:     x = 16'($urandom);
            endcase
            send_sample(x, 1'b0, '0);
        end
    endtask

    // stimulus
    initial
    begin
        int          sent;
        int          n;
        int unsigned outer_v;
        int unsigned axis_v;
        int unsigned inner_v;
        int unsigned per;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = amr_pkg::REG_OUTER_COUNT;
        cfg_data          = '0;
        sample_bus.valid  = 1'b0;
        sample_bus.sample = '0;
        failures          = 0;
        idle_run          = 0;
        burst_left        = 0;
        dirty             = 1'b0;
        outer_cnt         = 1;
        axis_len          = 1;
        inner_cnt         = 1;
        inner_at          = 0;
        axis_at           = 0;
        outer_at          = 0;
        foreach (axis_sums[i])
            axis_sums[i] = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
                write_reg(plan[i].reg_index, plan[i].reg_value);
            else
                send_sample(plan[i].sample, plan[i].pinned, plan[i].beat);
        end

        // longest axis, most negative elements: sum hits the bottom of its range
        write_reg(amr_pkg::REG_OUTER_COUNT, 17'h1FFFF);
        write_reg(amr_pkg::REG_AXIS_LENGTH, 17'h1FFF);
        write_reg(amr_pkg::REG_INNER_COUNT, 17'd1);
        stream(amr_pkg::MAX_AXIS, FILL_MIN);

        // widest inner span, one mean per element, wraps into the next tensor
        write_reg(amr_pkg::REG_OUTER_COUNT, 17'd1);
        write_reg(amr_pkg::REG_AXIS_LENGTH, 17'd1);
        write_reg(amr_pkg::REG_INNER_COUNT, 17'h7FF);
        stream(amr_pkg::MAX_INNER + 6, FILL_CORNER);

        // exact upper limits, abandoned early
        write_reg(amr_pkg::REG_OUTER_COUNT, 17'(amr_pkg::OUTER_LIMIT));
        write_reg(amr_pkg::REG_AXIS_LENGTH, 17'(amr_pkg::MAX_AXIS));
        write_reg(amr_pkg::REG_INNER_COUNT, 17'(amr_pkg::MAX_INNER));
        stream(16, FILL_RANDOM);

        // random shapes, mostly whole tensors, some cut short by a restart
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            outer_v = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
            case ($urandom_range(0, 9))
                0:       axis_v = 0;
                1:       axis_v = $urandom_range(9, 48);
                default: axis_v = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 9))
                0:       inner_v = 0;
                1:       inner_v = $urandom_range(9, 40);
                default: inner_v = $urandom_range(1, 8);
            endcase
            if ($urandom_range(0, 5) == 0)
                write_reg(REG_SPARE, 17'($urandom));
            write_reg(amr_pkg::REG_OUTER_COUNT, 17'(outer_v));
            write_reg(amr_pkg::REG_AXIS_LENGTH, {4'($urandom), 13'(axis_v)});
            write_reg(amr_pkg::REG_INNER_COUNT, {6'($urandom), 11'(inner_v)});
            per = clamp_size(outer_v, amr_pkg::OUTER_LIMIT) *
                  clamp_size(axis_v, amr_pkg::MAX_AXIS) *
                  clamp_size(inner_v, amr_pkg::MAX_INNER);
            if (per > PHASE_CAP || $urandom_range(0, 4) == 0)
                n = $urandom_range(1, (per > PHASE_CAP) ? PHASE_CAP : per);
            else
                n = per * $urandom_range(1, 3);
            stream(n, ($urandom_range(0, 5) == 0) ? FILL_CORNER : FILL_RANDOM);
            sent += n;
        end

        // drain and settle
        @(negedge clk);
        sample_bus.valid <= 1'b0;
        while (pending_means.size() != 0)
            @(negedge clk);
        repeat (IDLE_CYCLES) @(negedge clk);
        if (failures == 0)
            $display("axis_mean_reduce verification clean");
        else
            $display("axis_mean_reduce verification failed");
        $finish;
    end

endmodule
